### rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg: shared types and constants of the LZW stream compressor
// Dictionary entry layouts, packer command and sequencer state codes.
// ----------------------------------------------------------------------------
package lzwc_pkg;

   localparam logic [11:0] CODE_CLEAR  = 12'd256;
   localparam logic [11:0] CODE_EOD    = 12'd257;
   localparam logic [12:0] CODE_FIRST  = 13'd258;
   localparam logic [12:0] CODE_LIMIT  = 13'd4096;
   localparam logic [3:0]  MIN_BITS    = 4'd9;
   localparam logic [3:0]  MAX_BITS    = 4'd12;
   localparam logic [13:0] CHAIN_LIMIT = 14'd4096;

   typedef struct packed {
      logic        valid;
      logic [19:0] key;
      logic [11:0] link;
      logic [11:0] code;
   } hash_entry_type;

   typedef struct packed {
      logic [19:0] key;
      logic [11:0] link;
      logic [11:0] code;
   } chain_entry_type;

   // One code handed to the bit packer.
   typedef struct packed {
      logic [11:0] code;
      logic [3:0]  width;
      logic        pad;
      logic        fin;
      logic        eos;
   } pk_cmd_type;

   typedef enum logic [13:0] {
      ST_CLR        = 14'b00000000000001,
      ST_IDLE       = 14'b00000000000010,
      ST_START      = 14'b00000000000100,
      ST_HASH1      = 14'b00000000001000,
      ST_HASH2      = 14'b00000000010000,
      ST_HASH3      = 14'b00000000100000,
      ST_HREAD      = 14'b00000001000000,
      ST_HCHECK     = 14'b00000010000000,
      ST_CREAD      = 14'b00000100000000,
      ST_CCHECK     = 14'b00001000000000,
      ST_MISS       = 14'b00010000000000,
      ST_OVF        = 14'b00100000000000,
      ST_FLUSH_CODE = 14'b01000000000000,
      ST_FLUSH_EOD  = 14'b10000000000000
   } state_type;

endpackage

### rtl/lzwc_hash.sv
// ----------------------------------------------------------------------------
// lzwc_hash: dictionary hash index pipeline
// Three register stages reduce the keyed hash modulo the slot count minus one.
// ----------------------------------------------------------------------------
module lzwc_hash #(
   parameter int HASH_SLOTS = 8192
) (
   input  logic                          clock,
   input  logic [19:0]                   key,
   output logic [$clog2(HASH_SLOTS)-1:0] idx
);

   localparam int HW  = $clog2(HASH_SLOTS);
   localparam int HW1 = HW + 1;
   localparam longint unsigned Mod   = longint'(HASH_SLOTS) - 1;
   localparam longint unsigned Recip = (64'd1 << 32) / Mod;
   localparam longint unsigned Bias  = 64'h80800000 % Mod;
   localparam int RW = $clog2(Recip + 1);
   localparam int PW = 20 + RW;

   logic [19:0]  w;
   logic [19:0]  w_ff;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-33:0] q;
   logic [23:0]  t;
   logic [HW:0]  r_ff, r_in, r1;
   logic [HW:0]  s_ff, s_in;

   // The constant high bits of the hash fold into a fixed bias added after reduction.
   assign w       = key ^ (key >> 8) ^ (key >> 16) ^ 20'h08000;
   assign prod_in = PW'(w) * PW'(Recip);
   assign q       = prod_ff[PW-1:32];
   assign t       = 24'(w_ff) - 24'(q) * 24'(Mod);
   assign r_in    = t[HW:0];
   assign r1      = (r_ff >= HW1'(Mod)) ? (r_ff - HW1'(Mod)) : r_ff;
   assign s_in    = r1 + HW1'(Bias);
   assign idx     = (s_ff >= HW1'(Mod)) ? HW'(s_ff - HW1'(Mod)) : HW'(s_ff);

   always_ff @(posedge clock) begin
      w_ff    <= w;
      prod_ff <= prod_in;
      r_ff    <= r_in;
      s_ff    <= s_in;
   end

endmodule

### rtl/lzwc_dict_mem.sv
// ----------------------------------------------------------------------------
// lzwc_dict_mem: dictionary storage
// Hash slot memory and overflow chain memory, one read and one write port each.
// ----------------------------------------------------------------------------
module lzwc_dict_mem #(
   parameter int HASH_SLOTS  = 8192,
   parameter int CHAIN_SLOTS = 4096
) (
   input  logic                           clock,
   input  logic [$clog2(HASH_SLOTS)-1:0]  h_raddr,
   output lzwc_pkg::hash_entry_type       h_rdata,
   input  logic                           h_we,
   input  logic [$clog2(HASH_SLOTS)-1:0]  h_waddr,
   input  lzwc_pkg::hash_entry_type       h_wdata,
   input  logic [$clog2(CHAIN_SLOTS)-1:0] c_raddr,
   output lzwc_pkg::chain_entry_type      c_rdata,
   input  logic                           c_we,
   input  logic [$clog2(CHAIN_SLOTS)-1:0] c_waddr,
   input  lzwc_pkg::chain_entry_type      c_wdata
);

   lzwc_pkg::hash_entry_type  hash_mem  [HASH_SLOTS];
   lzwc_pkg::chain_entry_type chain_mem [CHAIN_SLOTS];

   always_ff @(posedge clock) begin
      h_rdata <= hash_mem[h_raddr];
      if (h_we) begin
         hash_mem[h_waddr] <= h_wdata;
      end
   end

   always_ff @(posedge clock) begin
      c_rdata <= chain_mem[c_raddr];
      if (c_we) begin
         chain_mem[c_waddr] <= c_wdata;
      end
   end

endmodule

### rtl/lzwc_packer.sv
// ----------------------------------------------------------------------------
// lzwc_packer: MSB-first bit packer with output register
// Takes one code at a time and drains whole bytes, one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module lzwc_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  lzwc_pkg::pk_cmd_type cmd,
   output logic                 cmd_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_burst,
   output logic                 rsp_end_of_stream
);

   logic [23:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic        eos_ff, eos_in;
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        ol_ff, ol_in;
   logic        oe_ff, oe_in;

   always_comb begin
      logic [11:0] mask;
      logic [4:0]  tot;
      logic [23:0] sh;
      logic [2:0]  padn;
      logic [4:0]  rem;
      logic        free;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      eos_in = eos_ff;
      ov_in  = ov_ff;
      ob_in  = ob_ff;
      ol_in  = ol_ff;
      oe_in  = oe_ff;
      mask   = 12'((13'd1 << cmd.width) - 13'd1);
      tot    = cnt_ff + 5'(cmd.width);
      sh     = (acc_ff << cmd.width) | 24'(cmd.code & mask);
      padn   = cmd.pad ? 3'(4'd8 - {1'b0, tot[2:0]}) : 3'd0;
      rem    = cnt_ff - 5'd8;
      free   = !ov_ff || !rsp_stall;
      cmd_ready = (cnt_ff < 5'd8);
      if (!rsp_stall) begin
         ov_in = 1'b0;
      end
      if (cmd_valid && cmd_ready) begin
         acc_in = sh << padn;
         cnt_in = tot + 5'(padn);
         fin_in = cmd.fin;
         eos_in = cmd.eos;
      end else if (!cmd_ready && free) begin
         // The byte that leaves fewer than eight bits behind closes this code.
         ob_in  = 8'(acc_ff >> rem);
         ov_in  = 1'b1;
         ol_in  = fin_ff && (rem < 5'd8);
         oe_in  = eos_ff && (rem < 5'd8);
         cnt_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
         ov_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
      acc_ff <= acc_in;
      fin_ff <= fin_in;
      eos_ff <= eos_in;
      ob_ff  <= ob_in;
      ol_ff  <= ol_in;
      oe_ff  <= oe_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_out_byte      = ob_ff;
   assign rsp_last_of_burst = ol_ff;
   assign rsp_end_of_stream = oe_ff;

endmodule

### rtl/lzw_stream_compressor.sv
// ----------------------------------------------------------------------------
// lzw_stream_compressor: LZW compressor, 9 to 12 bit codes, MSB-first packing
// Sequencer around a hashed dictionary memory with overflow chains.
// ----------------------------------------------------------------------------
// A byte that hits in its hash slot passes through ST_HASH1, ST_HASH2, ST_HASH3, ST_HREAD and
// ST_HCHECK; each chain entry probed adds ST_CREAD and ST_CCHECK, and a miss adds ST_MISS.
// The first byte of a run goes through ST_START. Output bytes drain one per cycle behind
// that while rsp_stall is low. After reset, after each run and after the dictionary fills,
// a clearing pass sweeps every hash slot, during which no item is accepted.
module lzw_stream_compressor #(
   parameter int HASH_SLOTS  = 8192,
   parameter int CHAIN_SLOTS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in_run,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_burst,
   output logic       rsp_end_of_stream
);

   localparam int HW = $clog2(HASH_SLOTS);
   localparam int CW = $clog2(CHAIN_SLOTS);

   lzwc_pkg::state_type state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [19:0] key_ff, key_in;
   logic [11:0] cur_ff, cur_in;
   logic [12:0] nf_ff, nf_in;
   logic [3:0]  bits_ff, bits_in;
   logic [11:0] fill_ff, fill_in;
   logic        run_ff, run_in;
   logic        clr_pend_ff, clr_pend_in;
   logic [HW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [HW-1:0] idx_ff, idx_in;
   lzwc_pkg::hash_entry_type hent_ff, hent_in;
   logic        empty_ff, empty_in;
   logic [11:0] link_ff, link_in;

   logic [HW-1:0] hash_idx;
   lzwc_pkg::hash_entry_type  h_rdata, h_wdata;
   lzwc_pkg::chain_entry_type c_rdata, c_wdata;
   logic          h_we, c_we;
   logic [HW-1:0] h_waddr;
   logic [CW-1:0] c_waddr;

   logic                 pk_valid, pk_ready;
   lzwc_pkg::pk_cmd_type pk_cmd;

   lzwc_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
      .clock (clock),
      .key   (key_ff),
      .idx   (hash_idx)
   );

   lzwc_dict_mem #(.HASH_SLOTS(HASH_SLOTS), .CHAIN_SLOTS(CHAIN_SLOTS)) u_mem (
      .clock   (clock),
      .h_raddr (hash_idx),
      .h_rdata (h_rdata),
      .h_we    (h_we),
      .h_waddr (h_waddr),
      .h_wdata (h_wdata),
      .c_raddr (CW'(link_ff)),
      .c_rdata (c_rdata),
      .c_we    (c_we),
      .c_waddr (c_waddr),
      .c_wdata (c_wdata)
   );

   lzwc_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (pk_valid),
      .cmd               (pk_cmd),
      .cmd_ready         (pk_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   assign req_stall = (state_ff != lzwc_pkg::ST_IDLE);

   always_comb begin
      lzwc_pkg::state_type end_st;
      logic [12:0] nf_inc;
      logic        ovf;
      logic [13:0] fill_next;
      logic        room;
      logic [11:0] nlink;
      state_in    = state_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      key_in      = key_ff;
      cur_in      = cur_ff;
      nf_in       = nf_ff;
      bits_in     = bits_ff;
      fill_in     = fill_ff;
      run_in      = run_ff;
      clr_pend_in = clr_pend_ff;
      clr_cnt_in  = clr_cnt_ff;
      idx_in      = idx_ff;
      hent_in     = hent_ff;
      empty_in    = empty_ff;
      link_in     = link_ff;
      h_we        = 1'b0;
      h_waddr     = idx_ff;
      h_wdata     = hent_ff;
      c_we        = 1'b0;
      c_wdata     = '0;
      pk_valid    = 1'b0;
      pk_cmd      = '0;
      nf_inc      = nf_ff + 13'd1;
      ovf         = (nf_inc >= lzwc_pkg::CODE_LIMIT);
      fill_next   = {2'b00, fill_ff} + 14'd1;
      room        = (fill_next < 14'(CHAIN_SLOTS)) && (fill_next < lzwc_pkg::CHAIN_LIMIT);
      c_waddr     = CW'(fill_next);
      nlink       = h_rdata.link;
      if (state_ff == lzwc_pkg::ST_CCHECK) begin
         nlink = c_rdata.link;
      end
      if (last_ff) begin
         end_st = lzwc_pkg::ST_FLUSH_CODE;
      end else if (clr_pend_ff) begin
         end_st = lzwc_pkg::ST_CLR;
      end else begin
         end_st = lzwc_pkg::ST_IDLE;
      end

      unique case (state_ff)
         lzwc_pkg::ST_CLR: begin
            h_we        = 1'b1;
            h_waddr     = clr_cnt_ff;
            h_wdata     = '0;
            clr_pend_in = 1'b0;
            clr_cnt_in  = clr_cnt_ff + HW'(1);
            if (clr_cnt_ff == HW'(HASH_SLOTS - 1)) begin
               clr_cnt_in = '0;
               state_in   = lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               byte_in  = req_data_byte;
               last_in  = req_last_in_run;
               key_in   = {cur_ff, req_data_byte};
               state_in = run_ff ? lzwc_pkg::ST_HASH1 : lzwc_pkg::ST_START;
            end
         end
         lzwc_pkg::ST_START: begin
            if (pk_ready) begin
               pk_valid     = 1'b1;
               pk_cmd.code  = lzwc_pkg::CODE_CLEAR;
               pk_cmd.width = lzwc_pkg::MIN_BITS;
               pk_cmd.fin   = !last_ff;
               nf_in        = lzwc_pkg::CODE_FIRST;
               bits_in      = lzwc_pkg::MIN_BITS;
               fill_in      = '0;
               run_in       = 1'b1;
               cur_in       = {4'd0, byte_ff};
               state_in     = end_st;
            end
         end
         lzwc_pkg::ST_HASH1: state_in = lzwc_pkg::ST_HASH2;
         lzwc_pkg::ST_HASH2: state_in = lzwc_pkg::ST_HASH3;
         lzwc_pkg::ST_HASH3: state_in = lzwc_pkg::ST_HREAD;
         lzwc_pkg::ST_HREAD: begin
            idx_in   = hash_idx;
            state_in = lzwc_pkg::ST_HCHECK;
         end
         lzwc_pkg::ST_HCHECK, lzwc_pkg::ST_CCHECK: begin
            if (state_ff == lzwc_pkg::ST_HCHECK) begin
               hent_in = h_rdata;
            end
            if ((state_ff == lzwc_pkg::ST_HCHECK) && !h_rdata.valid) begin
               empty_in = 1'b1;
               state_in = lzwc_pkg::ST_MISS;
            end else if ((state_ff == lzwc_pkg::ST_HCHECK) && (h_rdata.key == key_ff)) begin
               cur_in   = h_rdata.code;
               state_in = end_st;
            end else if ((state_ff == lzwc_pkg::ST_CCHECK) && (c_rdata.key == key_ff)) begin
               cur_in   = c_rdata.code;
               state_in = end_st;
            end else if ((nlink == 12'd0) || (14'(nlink) >= 14'(CHAIN_SLOTS))) begin
               empty_in = 1'b0;
               state_in = lzwc_pkg::ST_MISS;
            end else begin
               link_in  = nlink;
               state_in = lzwc_pkg::ST_CREAD;
            end
         end
         lzwc_pkg::ST_CREAD: state_in = lzwc_pkg::ST_CCHECK;
         lzwc_pkg::ST_MISS: begin
            if (pk_ready) begin
               pk_valid     = 1'b1;
               pk_cmd.code  = cur_ff;
               pk_cmd.width = bits_ff;
               pk_cmd.fin   = !last_ff && !ovf;
               if (empty_ff) begin
                  h_we    = 1'b1;
                  h_wdata = '{valid: 1'b1, key: key_ff, link: 12'd0, code: nf_ff[11:0]};
               end else if (room) begin
                  // New entry goes to the head of the slot's chain.
                  h_we         = 1'b1;
                  h_wdata      = hent_ff;
                  h_wdata.link = fill_next[11:0];
                  c_we         = 1'b1;
                  c_wdata      = '{key: key_ff, link: hent_ff.link, code: nf_ff[11:0]};
                  fill_in      = fill_next[11:0];
               end
               nf_in = nf_inc;
               if ((nf_inc >= (13'd1 << bits_ff)) && (bits_ff < lzwc_pkg::MAX_BITS)) begin
                  bits_in = bits_ff + 4'd1;
               end
               cur_in   = {4'd0, byte_ff};
               state_in = ovf ? lzwc_pkg::ST_OVF : end_st;
            end
         end
         lzwc_pkg::ST_OVF: begin
            if (pk_ready) begin
               pk_valid     = 1'b1;
               pk_cmd.code  = lzwc_pkg::CODE_CLEAR;
               pk_cmd.width = lzwc_pkg::MAX_BITS;
               pk_cmd.fin   = !last_ff;
               nf_in        = lzwc_pkg::CODE_FIRST;
               bits_in      = lzwc_pkg::MIN_BITS;
               fill_in      = '0;
               clr_pend_in  = 1'b1;
               state_in     = last_ff ? lzwc_pkg::ST_FLUSH_CODE : lzwc_pkg::ST_CLR;
            end
         end
         lzwc_pkg::ST_FLUSH_CODE: begin
            if (pk_ready) begin
               pk_valid     = 1'b1;
               pk_cmd.code  = cur_ff;
               pk_cmd.width = bits_ff;
               state_in     = lzwc_pkg::ST_FLUSH_EOD;
            end
         end
         lzwc_pkg::ST_FLUSH_EOD: begin
            if (pk_ready) begin
               pk_valid     = 1'b1;
               pk_cmd.code  = lzwc_pkg::CODE_EOD;
               pk_cmd.width = bits_ff;
               pk_cmd.pad   = 1'b1;
               pk_cmd.fin   = 1'b1;
               pk_cmd.eos   = 1'b1;
               run_in       = 1'b0;
               state_in     = lzwc_pkg::ST_CLR;
            end
         end
         default: state_in = lzwc_pkg::ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzwc_pkg::ST_CLR;
         cur_ff      <= '0;
         nf_ff       <= lzwc_pkg::CODE_FIRST;
         bits_ff     <= lzwc_pkg::MIN_BITS;
         fill_ff     <= '0;
         run_ff      <= 1'b0;
         clr_pend_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         nf_ff       <= nf_in;
         bits_ff     <= bits_in;
         fill_ff     <= fill_in;
         run_ff      <= run_in;
         clr_pend_ff <= clr_pend_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      hent_ff  <= hent_in;
      empty_ff <= empty_in;
      link_ff  <= link_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != lzwc_pkg::ST_IDLE))
      else $error("sequencer stayed idle after taking an item");

   a_code_width: assert property (@(posedge clock) disable iff (reset)
      (bits_ff >= lzwc_pkg::MIN_BITS) && (bits_ff <= lzwc_pkg::MAX_BITS))
      else $error("code width out of range");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwc_pkg::ST_OVF) |-> (nf_ff == lzwc_pkg::CODE_LIMIT))
      else $error("dictionary reset without a full code space");

   a_run_after_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lzwc_pkg::ST_START) && pk_ready) |=> run_ff)
      else $error("run not marked open after CLEAR");

endmodule
